// ----- rtl/bda_pkg.sv -----
// ----------------------------------------------------------------------------
// bda_pkg
// Shared widths, defaults and types of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned CAP_W          = 8;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned COUNT_W        = 5;
  localparam int unsigned BCD_W          = 4;
  localparam int unsigned VALUE_BITS_DEF = 64;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- rtl/bda_if.sv -----
// ----------------------------------------------------------------------------
// bda_in_if / bda_out_if
// Valid/ready channels of the converter: the input value and the characters.
// ----------------------------------------------------------------------------
interface bda_in_if
  import bda_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [CAP_W-1:0]   capacity;

  modport source (output valid, output value, output capacity, input ready);
  modport sink   (input valid, input value, input capacity, output ready);
endinterface

interface bda_out_if
  import bda_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  out_char;
  logic               is_last;
  logic               failed;
  logic [COUNT_W-1:0] digit_count;

  modport source (output valid, output out_char, output is_last, output failed,
                  output digit_count, input ready);
  modport sink   (input valid, input out_char, input is_last, input failed,
                  input digit_count, output ready);
endinterface

// ----- rtl/bda_cell.sv -----
// ----------------------------------------------------------------------------
// bda_cell
// One BCD digit of the double dabble chain.
// ----------------------------------------------------------------------------
module bda_cell
  import bda_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic             bit_i,
  input  logic [BCD_W-1:0] digit_i,
  output logic             bit_o,
  output logic [BCD_W-1:0] digit_o
);

  logic [BCD_W-1:0] digit_q, digit_d;
  logic [BCD_W-1:0] adj;

  assign adj     = (digit_q >= BCD_W'(5)) ? digit_q + BCD_W'(3) : digit_q;
  assign bit_o   = adj[BCD_W-1];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[BCD_W-2:0], bit_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

// ----- rtl/binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary value to decimal ASCII, one character per
// transfer, through a chain of double dabble digit cells.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                                     | Transfer
// in_i    | in  | value, capacity                             | valid && ready
// out_o   | out | out_char, is_last, failed, digit_count      | valid && ready
//
// An item is accepted, shifted bit by bit through the cell chain, trimmed of
// leading zero digits and checked against the capacity, then emitted as its
// digit characters and a NUL terminator, or as a single failure item.
// The chain handles one item at a time; in_i.ready is high only when idle.
// A stalled output holds its character and pauses the digit shifting.
// Reset returns the control to idle and empties the output register.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
  import bda_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bda_in_if.sink           in_i,
  bda_out_if.source        out_o
);

  localparam int unsigned NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned NDIG_W     = $clog2(NUM_DIGITS + 1);
  localparam int unsigned BITCNT_W   = $clog2(VALUE_BITS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CONV = 6'b000010,
    S_TRIM = 6'b000100,
    S_EMIT = 6'b001000,
    S_TERM = 6'b010000,
    S_FAIL = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [CAP_W-1:0]      cap_q, cap_d;
  logic [BITCNT_W-1:0]   bits_q, bits_d;
  logic [NDIG_W-1:0]     ndig_q, ndig_d;
  logic [NDIG_W-1:0]     rem_q, rem_d;

  logic                  ov_q, ov_d;
  logic [CHAR_W-1:0]     och_q, och_d;
  logic                  olast_q, olast_d;
  logic                  ofail_q, ofail_d;
  logic [COUNT_W-1:0]    ocnt_q, ocnt_d;

  cell_ctrl_t            ctrl;
  logic                  out_free;
  logic                  too_small;
  logic [BCD_W-1:0]      top_digit;
  logic [NUM_DIGITS:0]   carry;
  logic [BCD_W-1:0]      digit [NUM_DIGITS];

  assign carry[0] = val_q[VALUE_BITS-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic [BCD_W-1:0] prev_digit;
    if (i == 0) begin : g_first
      assign prev_digit = '0;
    end else begin : g_rest
      assign prev_digit = digit[i-1];
    end
    bda_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_i   (carry[i]),
      .digit_i (prev_digit),
      .bit_o   (carry[i+1]),
      .digit_o (digit[i])
    );
  end

  assign top_digit = digit[NUM_DIGITS-1];
  assign out_free  = !ov_q || out_o.ready;
  assign too_small = (cap_q == '0) ||
                     ((9'(ndig_q) + 9'd1) > {1'b0, cap_q});

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    cap_d       = cap_q;
    bits_d      = bits_q;
    ndig_d      = ndig_q;
    rem_d       = rem_q;
    ctrl        = '0;
    ov_d        = ov_q && !out_o.ready;
    och_d       = och_q;
    olast_d     = olast_q;
    ofail_d     = ofail_q;
    ocnt_d      = ocnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          val_d      = in_i.value[VALUE_BITS-1:0];
          cap_d      = in_i.capacity;
          bits_d     = BITCNT_W'(VALUE_BITS);
          ctrl.clear = 1'b1;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.dabble = 1'b1;
        val_d       = val_q << 1;
        bits_d      = bits_q - BITCNT_W'(1);
        if (bits_q == BITCNT_W'(1)) begin
          ndig_d  = NDIG_W'(NUM_DIGITS);
          state_d = S_TRIM;
        end
      end
      S_TRIM: begin
        if (top_digit == '0 && ndig_q > NDIG_W'(1)) begin
          ctrl.shift = 1'b1;
          ndig_d     = ndig_q - NDIG_W'(1);
        end else if (too_small) begin
          state_d = S_FAIL;
        end else begin
          rem_d   = ndig_q;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_d       = 1'b1;
          och_d      = CHAR_ZERO | {{(CHAR_W-BCD_W){1'b0}}, top_digit};
          olast_d    = 1'b0;
          ofail_d    = 1'b0;
          ocnt_d     = '0;
          ctrl.shift = 1'b1;
          rem_d      = rem_q - NDIG_W'(1);
          if (rem_q == NDIG_W'(1)) begin
            state_d = S_TERM;
          end
        end
      end
      S_TERM: begin
        if (out_free) begin
          ov_d    = 1'b1;
          och_d   = CHAR_NUL;
          olast_d = 1'b1;
          ofail_d = 1'b0;
          ocnt_d  = COUNT_W'(ndig_q);
          state_d = S_IDLE;
        end
      end
      S_FAIL: begin
        if (out_free) begin
          ov_d    = 1'b1;
          och_d   = CHAR_NUL;
          olast_d = 1'b1;
          ofail_d = 1'b1;
          ocnt_d  = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    cap_q   <= cap_d;
    bits_q  <= bits_d;
    ndig_q  <= ndig_d;
    rem_q   <= rem_d;
    och_q   <= och_d;
    olast_q <= olast_d;
    ofail_q <= ofail_d;
    ocnt_q  <= ocnt_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.out_char    = och_q;
  assign out_o.is_last     = olast_q;
  assign out_o.failed      = ofail_q;
  assign out_o.digit_count = ocnt_q;

  // The top digit of the chain must be legal BCD once conversion has finished.
  a_bcd_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRIM || state_q == S_EMIT) |-> top_digit <= BCD_W'(9))
    else $error("digit chain holds a non-BCD digit");

  // An accepted transfer always starts a conversion.
  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> state_q == S_CONV)
    else $error("accepted input did not start conversion");

  // A failure is a single terminating item without digits.
  a_fail_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ofail_q) |-> (olast_q && och_q == CHAR_NUL && ocnt_q == '0))
    else $error("malformed failure item");

  // Characters before the terminator are decimal digits.
  a_digit_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !olast_q) |-> (och_q >= CHAR_ZERO && och_q <= CHAR_ZERO + 8'd9))
    else $error("non-digit character emitted");

  // Remaining digit count never exceeds the trimmed digit count.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (rem_q <= ndig_q && rem_q != '0))
    else $error("digit countdown out of range");

endmodule

// ----- tb/sv/binary_to_decimal_ascii_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_tb
// Self-checking bench for the decimal ASCII converter. A queue of values and
// capacities feeds a valid/ready driver. Each accepted transfer is turned
// into the expected character sequence by a local decimal formatter, and a
// monitor compares every character transfer against it. Directed corner cases
// come first. Random phases follow; the later ones add sender gaps, receiver stalls or both.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_tb;
  import bda_pkg::*;

  localparam int unsigned VALUE_BITS    = VALUE_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS   = 65;
  localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [CAP_W-1:0]   capacity;
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;
    bit                 drain;
  } conversion_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  out_char;
    logic               is_last;
    logic               failed;
    logic [COUNT_W-1:0] digit_count;
  } char_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bda_in_if  in_if ();
  bda_out_if out_if ();

  conversion_t pending_q[$];
  char_item_t  expected_chars_q[$];
  int unsigned stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  binary_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned count_digits(logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] rest;
    int unsigned n;
    rest = value & VALUE_MASK;
    n = 1;
    while (rest >= 10) begin
      rest = rest / 10;
      n++;
    end
    return n;
  endfunction

  function automatic void queue_decimal_text(logic [VALUE_W-1:0] value,
                                             logic [CAP_W-1:0] capacity);
    logic [VALUE_W-1:0] rest;
    logic [CHAR_W-1:0]  digits[$];
    int unsigned        n;
    rest = value & VALUE_MASK;
    n = count_digits(rest);
    if (capacity == 0 || n + 1 > capacity) begin
      expected_chars_q.push_back('{CHAR_NUL, 1'b1, 1'b1, '0});
      return;
    end
    repeat (n) begin
      digits.push_front(CHAR_ZERO + CHAR_W'(rest % 10));
      rest = rest / 10;
    end
    foreach (digits[i]) expected_chars_q.push_back('{digits[i], 1'b0, 1'b0, '0});
    expected_chars_q.push_back('{CHAR_NUL, 1'b1, 1'b0, COUNT_W'(n)});
  endfunction

  task automatic add_conversion(logic [VALUE_W-1:0] value, logic [CAP_W-1:0] capacity,
                                int unsigned send_pct, int unsigned recv_pct);
    pending_q.push_back('{value, capacity, send_pct, recv_pct, 1'b0});
  endtask

  task automatic add_drain();
    pending_q.push_back('{'0, '0, 0, 0, 1'b1});
  endtask

  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      next_valid = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        queue_decimal_text(in_if.value, in_if.capacity);
        void'(pending_q.pop_front());
        next_valid = 1'b0;
      end
      if (!next_valid && pending_q.size() > 0) begin
        if (pending_q[0].drain) begin
          if (expected_chars_q.size() == 0) void'(pending_q.pop_front());
        end else if ($urandom_range(99) >= pending_q[0].send_idle_pct) begin
          in_if.value    <= pending_q[0].value;
          in_if.capacity <= pending_q[0].capacity;
          stall_pct      <= pending_q[0].recv_stall_pct;
          next_valid = 1'b1;
        end
      end
      in_if.valid <= next_valid;
    end
  end

  always @(posedge clk) begin
    char_item_t seen;
    char_item_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        seen = '{out_if.out_char, out_if.is_last, out_if.failed, out_if.digit_count};
        if (expected_chars_q.size() == 0) begin
          $display("%0t: unexpected transfer: char %h last %b failed %b count %0d",
                   $time, seen.out_char, seen.is_last, seen.failed, seen.digit_count);
          error_count++;
        end else begin
          want = expected_chars_q.pop_front();
          if (seen.out_char !== want.out_char || seen.is_last !== want.is_last ||
              seen.failed !== want.failed || seen.digit_count !== want.digit_count) begin
            $display("%0t: mismatch: expected char %h last %b failed %b count %0d, %s",
                     $time, want.out_char, want.is_last, want.failed, want.digit_count,
                     $sformatf("got char %h last %b failed %b count %0d",
                               seen.out_char, seen.is_last, seen.failed, seen.digit_count));
            error_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned        send_pcts[4];
    int unsigned        recv_pcts[4];
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] power;
    logic [CAP_W-1:0]   capacity;
    int unsigned        n;
    bit                 quiet;

    send_pcts = '{0, 58, 0, 32};
    recv_pcts = '{0, 0, 58, 32};

    add_conversion(64'd0, 8'd0, 0, 0);
    add_conversion(64'd0, 8'd1, 0, 0);
    add_conversion(64'd0, 8'd2, 0, 0);
    add_conversion(64'd0, 8'd255, 0, 0);
    add_conversion(64'd1, 8'd2, 0, 0);
    add_conversion(64'd9, 8'd2, 0, 0);
    add_conversion(64'd10, 8'd2, 0, 0);
    add_conversion(64'd10, 8'd3, 0, 0);
    add_conversion(64'd99, 8'd3, 0, 0);
    add_conversion(64'd100, 8'd4, 0, 0);
    add_conversion(64'd18446744073709551615, 8'd20, 0, 0);
    add_conversion(64'd18446744073709551615, 8'd21, 0, 0);
    add_conversion(64'd18446744073709551615, 8'd255, 0, 0);
    add_conversion(64'd10000000000000000000, 8'd21, 0, 0);
    add_conversion(64'd10000000000000000000, 8'd20, 0, 0);
    add_conversion(64'd9999999999999999999, 8'd20, 0, 0);
    add_conversion(64'd9999999999999999999, 8'd19, 0, 0);
    add_conversion(64'd12345678901234567890, 8'd128, 0, 0);
    add_conversion(64'h8000_0000_0000_0000, 8'd170, 0, 0);
    add_conversion(64'h5555_5555_5555_5555, 8'd85, 0, 0);
    add_conversion(64'hAAAA_AAAA_AAAA_AAAA, 8'd22, 0, 0);
    add_conversion(64'h0000_0000_FFFF_FFFF, 8'd11, 0, 0);
    add_drain();

    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(3))
          0: value = {$urandom, $urandom};
          1: value = {$urandom, $urandom} >> $urandom_range(63);
          2: begin
            power = 64'd1;
            repeat ($urandom_range(19)) power = power * 10;
            value = power + $urandom_range(2) - 1;
          end
          default: value = $urandom_range(999);
        endcase
        n = count_digits(value);
        case ($urandom_range(3))
          0: capacity = CAP_W'($urandom_range(255));
          1, 2: capacity = CAP_W'(n + $urandom_range(2));
          default: capacity = CAP_W'($urandom_range(n + 1));
        endcase
        quiet = (i % 32) < 8;
        add_conversion(value, capacity, quiet ? 0 : send_pcts[phase],
                       quiet ? 0 : recv_pcts[phase]);
        if (i == PHASE_ITEMS / 2) add_drain();
      end
      add_drain();
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || expected_chars_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- binary_to_decimal_ascii.f -----
rtl/bda_pkg.sv
rtl/bda_if.sv
rtl/bda_cell.sv
rtl/binary_to_decimal_ascii.sv
tb/sv/binary_to_decimal_ascii_tb.sv
